>>> rtl/laq_pkg.sv
// Shared types, codes and constants for the linear array queue.
package laq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 7;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_DISP = 2'd2
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_EMPTY     = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DEQ_OUT,
        ST_WALK_OUT,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  latch_req;
        logic  enq_commit;
        logic  deq_commit;
        logic  walk_start;
        logic  walk_next;
        logic  out_load;
        stat_t out_status;
        logic  out_use_rdata;
        logic  out_last;
    } laq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t req;
        logic empty;
        logic enq_ovf;
        logic out_free;
        logic walk_last;
    } laq_sts_t;

endpackage

>>> rtl/laq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module laq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/laq_ctrl.sv
// Request sequencer for the linear array queue.
module laq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  laq_pkg::laq_sts_t sts,
    output laq_pkg::laq_cmd_t cmd
);
    import laq_pkg::*;

    state_t state_reg, state_next;
    stat_t  emit_reg, emit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            emit_reg  <= STAT_OK;
        end else begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb begin
        logic  quick;
        stat_t quick_code;
        state_next = state_reg;
        emit_next  = emit_reg;
        cmd        = '0;
        quick      = 1'b0;
        quick_code = STAT_OK;
        s_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (sts.req)
                    REQ_ENQ: begin
                        quick          = 1'b1;
                        quick_code     = sts.enq_ovf ? STAT_OVERFLOW : STAT_OK;
                        cmd.enq_commit = !sts.enq_ovf;
                    end
                    REQ_DEQ: begin
                        if (sts.empty) begin
                            quick      = 1'b1;
                            quick_code = STAT_UNDERFLOW;
                        end else begin
                            cmd.deq_commit = 1'b1;
                            state_next     = ST_DEQ_OUT;
                        end
                    end
                    REQ_DISP: begin
                        if (sts.empty) begin
                            quick      = 1'b1;
                            quick_code = STAT_EMPTY;
                        end else begin
                            cmd.walk_start = 1'b1;
                            state_next     = ST_WALK_OUT;
                        end
                    end
                    default: begin
                        // unknown request: drop without a result
                        state_next = ST_IDLE;
                    end
                endcase
                if (quick) begin
                    if (sts.out_free) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = quick_code;
                        cmd.out_last   = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        emit_next  = quick_code;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DEQ_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load      = 1'b1;
                    cmd.out_status    = STAT_OK;
                    cmd.out_use_rdata = 1'b1;
                    cmd.out_last      = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_WALK_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load      = 1'b1;
                    cmd.out_status    = STAT_OK;
                    cmd.out_use_rdata = 1'b1;
                    cmd.out_last      = sts.walk_last;
                    if (sts.walk_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.walk_next = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = emit_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending beat");

    a_accept_starts_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECIDE))
        else $error("accepted request not decoded");

    a_one_memory_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.enq_commit, cmd.deq_commit, cmd.walk_start, cmd.walk_next}) <= 1)
        else $error("conflicting queue commands");

endmodule

>>> rtl/laq_dp.sv
// Datapath: queue indices, capacity register, store and result register.
module laq_dp #(
    parameter int DEPTH = laq_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [laq_pkg::REQ_W-1:0]         s_req_type,
    input  logic signed [laq_pkg::DATA_W-1:0] s_item_value,
    input  logic                              cfg_valid,
    input  logic [laq_pkg::CAP_W-1:0]         cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [laq_pkg::STAT_W-1:0]        m_status,
    output logic signed [laq_pkg::DATA_W-1:0] m_data_out,
    output logic                              m_last,
    input  laq_pkg::laq_cmd_t                 cmd,
    output laq_pkg::laq_sts_t                 sts
);
    import laq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

    logic [CAP_W-1:0]  cap_reg;
    logic [IDX_W-1:0]  head_reg, tail_reg, walk_reg;
    logic              empty_reg;
    req_t              req_reg;
    logic [DATA_W-1:0] item_reg;

    logic              m_valid_reg;
    stat_t             m_status_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_last_reg;

    logic [CAP_W-1:0]  cap_eff;
    logic [CAP_W-1:0]  tail_inc;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign cap_eff  = (cap_reg > DEPTH_C) ? DEPTH_C : cap_reg;
    assign tail_inc = {{(CAP_W-IDX_W){1'b0}}, tail_reg} + CAP_W'(1);

    assign sts.req       = req_reg;
    assign sts.empty     = empty_reg;
    assign sts.enq_ovf   = empty_reg ? (cap_reg == '0) : (tail_inc >= cap_eff);
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.walk_last = (walk_reg == tail_reg);

    assign ram_we    = cmd.enq_commit;
    assign ram_waddr = empty_reg ? '0 : tail_inc[IDX_W-1:0];
    assign ram_re    = cmd.deq_commit || cmd.walk_start || cmd.walk_next;
    assign ram_raddr = cmd.walk_next ? walk_reg + IDX_W'(1) : head_reg;

    laq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (cmd.enq_commit) begin
                empty_reg <= 1'b0;
                if (empty_reg) begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end else begin
                    tail_reg <= tail_inc[IDX_W-1:0];
                end
            end
            if (cmd.deq_commit) begin
                // last value out: back to the start state
                if (head_reg >= tail_reg) begin
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    empty_reg <= 1'b1;
                end else begin
                    head_reg <= head_reg + IDX_W'(1);
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_reg  <= req_t'(s_req_type);
            item_reg <= s_item_value;
        end
        if (cmd.walk_start) begin
            walk_reg <= head_reg;
        end else if (cmd.walk_next) begin
            walk_reg <= walk_reg + IDX_W'(1);
        end
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_status;
            m_data_reg   <= cmd.out_use_rdata ? ram_rdata : '0;
            m_last_reg   <= cmd.out_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_data_out = m_data_reg;
    assign m_last     = m_last_reg;

    a_head_not_past_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty_reg |-> (head_reg <= tail_reg))
        else $error("head index beyond tail");

    a_empty_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty queue not at start state");

    a_tail_in_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(cmd.enq_commit) && !empty_reg |-> (tail_inc < cap_eff))
        else $error("enqueue past capacity");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_next |-> (walk_reg < tail_reg))
        else $error("display walk beyond tail");

endmodule

>>> rtl/linear_array_queue_unit.sv
// Top level of the linear array queue: controller, datapath and store.
//
// Input channel s_*: one request per beat, s_req_type selects enqueue,
// dequeue or display; s_item_value is used by enqueue only. Result channel
// m_*: status, data and a last flag on the final beat of each request.
// Configuration channel cfg_*: capacity write, always ready; write it only
// while the block is idle.
//
// One request is handled at a time. Enqueue, and any request that ends in
// an error status, loads its result in the decide state, or from the emit
// state while the output register still holds a beat; dequeue loads it from
// the dequeue-output state, after the registered read of the store. Display
// walks the store from head to tail, one beat per cycle after the first read
// while m_ready does not stall. Results sit in an output register; a stall on
// m_ready holds that beat and the sequencer waits to load the next one.
//
// Reset clears head, tail and the result valid flag, marks the queue empty
// and sets capacity to 64. Store contents are not cleared.
module linear_array_queue_unit #(
    parameter int DEPTH = laq_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [laq_pkg::REQ_W-1:0]         s_req_type,
    input  logic signed [laq_pkg::DATA_W-1:0] s_item_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [laq_pkg::STAT_W-1:0]        m_status,
    output logic signed [laq_pkg::DATA_W-1:0] m_data_out,
    output logic                              m_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [laq_pkg::CAP_W-1:0]         cfg_data
);
    import laq_pkg::*;

    laq_cmd_t cmd;
    laq_sts_t sts;

    assign cfg_ready = 1'b1;

    laq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    laq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_req_type   (s_req_type),
        .s_item_value (s_item_value),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data_out   (m_data_out),
        .m_last       (m_last),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

>>> verif/laq_result_checker.sv
// Checker for the linear array queue: tracks queue state from accepted beats and compares results.
module laq_result_checker
    import laq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic signed [DATA_W-1:0] s_item_value,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [STAT_W-1:0]        m_status,
    input  logic signed [DATA_W-1:0] m_data_out,
    input  logic                     m_last,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data,
    output int                       mismatch_count,
    output int                       beats_waiting,
    output int                       beats_checked
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        stat_t                    status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } queue_beat_t;

    queue_beat_t              expected_beats[$];
    logic signed [DATA_W-1:0] held_values[DEPTH];
    logic [IDX_W-1:0]         head_idx;
    logic [IDX_W-1:0]         tail_idx;
    logic                     queue_empty;
    logic [CAP_W-1:0]         capacity;

    initial begin
        mismatch_count = 0;
        beats_waiting  = 0;
        beats_checked  = 0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 30) begin
            $display("[%0t] result mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic void push_beat(input stat_t st, input logic signed [DATA_W-1:0] d,
                                      input logic fin);
        queue_beat_t b;
        b.status = st;
        b.data   = d;
        b.last   = fin;
        expected_beats.push_back(b);
    endfunction

    task automatic predict_request(input logic [REQ_W-1:0] kind,
                                   input logic signed [DATA_W-1:0] value);
        int usable;
        logic signed [DATA_W-1:0] taken;
        // anything above the store depth counts as the full store
        usable = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
        case (kind)
            REQ_ENQ: begin
                if (queue_empty) begin
                    if (usable == 0) begin
                        push_beat(STAT_OVERFLOW, '0, 1'b1);
                    end else begin
                        head_idx       = '0;
                        tail_idx       = '0;
                        held_values[0] = value;
                        queue_empty    = 1'b0;
                        push_beat(STAT_OK, '0, 1'b1);
                    end
                end else if (usable == 0 || int'(tail_idx) + 1 >= usable
                             || int'(tail_idx) + 1 >= DEPTH) begin
                    push_beat(STAT_OVERFLOW, '0, 1'b1);
                end else begin
                    tail_idx              = tail_idx + 1'b1;
                    held_values[tail_idx] = value;
                    push_beat(STAT_OK, '0, 1'b1);
                end
            end
            REQ_DEQ: begin
                if (queue_empty) begin
                    push_beat(STAT_UNDERFLOW, '0, 1'b1);
                end else begin
                    taken = held_values[head_idx];
                    // last value out: back to the start state
                    if (head_idx >= tail_idx) begin
                        head_idx    = '0;
                        tail_idx    = '0;
                        queue_empty = 1'b1;
                    end else begin
                        head_idx = head_idx + 1'b1;
                    end
                    push_beat(STAT_OK, taken, 1'b1);
                end
            end
            REQ_DISP: begin
                if (queue_empty || head_idx > tail_idx) begin
                    push_beat(STAT_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = int'(head_idx); i <= int'(tail_idx) && i < DEPTH; i++) begin
                        push_beat(STAT_OK, held_values[i],
                                  (i == int'(tail_idx)) || (i + 1 == DEPTH));
                    end
                end
            end
            default: ; // unused code: drop silently
        endcase
    endtask

    always @(posedge aclk) begin : watch
        queue_beat_t want;
        if (!aresetn) begin
            expected_beats.delete();
            head_idx    = '0;
            tail_idx    = '0;
            queue_empty = 1'b1;
            capacity    = CAP_RESET;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat status %0d data %0d last %0b",
                                              m_status, m_data_out, m_last));
                end else begin
                    want = expected_beats.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  m_status, want.status));
                    end
                    if (m_data_out !== want.data) begin
                        report_mismatch($sformatf("data %0d, wanted %0d",
                                                  m_data_out, want.data));
                    end
                    if (m_last !== want.last) begin
                        report_mismatch($sformatf("last %0b, wanted %0b", m_last, want.last));
                    end
                    beats_checked++;
                end
            end
            if (s_valid && s_ready) begin
                predict_request(s_req_type, s_item_value);
            end
            if (cfg_valid && cfg_ready) begin
                capacity = cfg_data;
            end
        end
        beats_waiting = expected_beats.size();
    end

endmodule

>>> verif/tb_linear_array_queue_unit.sv
// Testbench top for the linear array queue: clock, reset, request stimulus, receiver and verdict.
module tb_linear_array_queue_unit;
    import laq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int RUN_LIMIT     = 40_000_000;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [REQ_W-1:0]         s_req_type;
    logic signed [DATA_W-1:0] s_item_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [STAT_W-1:0]        m_status;
    logic signed [DATA_W-1:0] m_data_out;
    logic                     m_last;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data;

    int   mismatch_count;
    int   beats_waiting;
    int   beats_checked;
    logic idle_on;
    int   hold_seq;
    int   n_enq;
    int   n_deq;
    int   n_disp;
    int   n_unused;
    int   n_cap_writes;

    linear_array_queue_unit dut (.*);

    laq_result_checker result_chk (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT);
        $display("run limit reached with %0d beats outstanding", beats_waiting);
        $display("tb_linear_array_queue_unit NOT OK");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_seen;
        hold_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= !(idle_on && $urandom_range(99) < 36);
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value);
        while (idle_on && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_item_value <= value;
        do @(posedge aclk); while (!s_ready);
        case (kind)
            REQ_ENQ:  n_enq++;
            REQ_DEQ:  n_deq++;
            REQ_DISP: n_disp++;
            default:  n_unused++;
        endcase
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (beats_waiting != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        // an unused code leaves nothing to wait for, so give the block time to settle
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cap_writes++;
    endtask

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] random_kind(input int fill_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) return REQ_UNUSED;
        if (roll < 8) return REQ_DISP;
        return ($urandom_range(99) < fill_pct) ? REQ_ENQ : REQ_DEQ;
    endfunction

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items,
                             input int fill_a, input int fill_b, input logic idle);
        write_capacity(cap);
        idle_on = idle;
        for (int i = 0; i < n_items; i++) begin
            send_request(random_kind(i < n_items / 2 ? fill_a : fill_b), random_value());
        end
    endtask

    initial begin
        s_valid      <= 1'b0;
        s_req_type   <= REQ_ENQ;
        s_item_value <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        aresetn      <= 1'b0;
        hold_seq     <= 0;
        idle_on = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue, unused code, extreme values
        send_request(REQ_DISP, '0);
        send_request(REQ_DEQ, '0);
        send_request(REQ_UNUSED, 32'sh1234_5678);
        send_request(REQ_ENQ, 32'sh7FFF_FFFF);
        send_request(REQ_ENQ, 32'sh8000_0000);
        send_request(REQ_ENQ, '0);
        send_request(REQ_ENQ, '1);
        send_request(REQ_ENQ, 32'shAAAA_AAAA);
        send_request(REQ_ENQ, 32'sh5555_5555);
        send_request(REQ_DISP, '0);
        send_request(REQ_DEQ, '0);
        send_request(REQ_DEQ, '0);

        // capacity below the fill level: overflow, held values still readable
        write_capacity(7'd3);
        send_request(REQ_ENQ, random_value());
        send_request(REQ_DISP, '0);
        repeat (4) send_request(REQ_DEQ, '0);
        repeat (4) send_request(REQ_ENQ, random_value());

        // zero capacity, both with values held and once empty
        write_capacity(7'd0);
        send_request(REQ_ENQ, random_value());
        repeat (3) send_request(REQ_DEQ, '0);
        send_request(REQ_ENQ, random_value());

        // fill past the store depth, then drain through a single slot
        run_phase(7'd127, 100, 95, 60, 1'b1);
        run_phase(7'd1, 100, 15, 45, 1'b1);
        run_phase(7'd64, 100, 70, 30, 1'b0);

        // hold the receiver off while requests keep coming
        write_capacity(7'($urandom_range(2, 63)));
        idle_on = 1'b0;
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 40; i++) begin
            send_request(random_kind(80), random_value());
        end

        run_phase(7'd0, 40, 50, 50, 1'b1);
        run_phase(7'($urandom_range(1, 127)), 100, 60, 40, 1'b1);

        wait_drained();
        $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d display, %0d unused code",
                 n_enq + n_deq + n_disp + n_unused, n_enq, n_deq, n_disp, n_unused);
        $display("checked %0d result beats over %0d capacity writes, %0d mismatches",
                 beats_checked, n_cap_writes, mismatch_count);
        if (mismatch_count == 0 && beats_waiting == 0) begin
            $display("tb_linear_array_queue_unit OK");
        end else begin
            $display("tb_linear_array_queue_unit NOT OK");
        end
        $finish;
    end

endmodule
